// File: rtl/atsq_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// ack-tracking send queue. No dependencies.
`timescale 1ns / 1ps

package atsq_pkg;

    // Sizing
    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_BITS    = 8;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Fixed port widths
    localparam int MODE_W   = 3;
    localparam int TAG_W    = 8;
    localparam int STATUS_W = 3;
    localparam int SLOTS_W  = 6;
    localparam int WIN_W    = 6;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_ENQ     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DEQ     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ACK     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TIMEOUT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FLUSH   = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_SEND   = 3'd4;

    localparam logic [WIN_W-1:0] WIN_RESET = 6'd8;

    // Datapath operations issued by the controller
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NONE        = 5'd0;
    localparam logic [OP_W-1:0] OP_LATCH       = 5'd1;
    localparam logic [OP_W-1:0] OP_ENQ         = 5'd2;
    localparam logic [OP_W-1:0] OP_RESULT      = 5'd3;
    localparam logic [OP_W-1:0] OP_RESEND      = 5'd4;
    localparam logic [OP_W-1:0] OP_CLR_RESEND  = 5'd5;
    localparam logic [OP_W-1:0] OP_SEND_HEAD   = 5'd6;
    localparam logic [OP_W-1:0] OP_SEND_TRACK  = 5'd7;
    localparam logic [OP_W-1:0] OP_SCAN_NEXT   = 5'd8;
    localparam logic [OP_W-1:0] OP_SEND_AT_PTR = 5'd9;
    localparam logic [OP_W-1:0] OP_PEND_RM     = 5'd10;
    localparam logic [OP_W-1:0] OP_TMO_PUSH    = 5'd11;
    localparam logic [OP_W-1:0] OP_OUT_RES     = 5'd12;
    localparam logic [OP_W-1:0] OP_OUT_PEND    = 5'd13;
    localparam logic [OP_W-1:0] OP_OUT_SEND    = 5'd14;
    localparam logic [OP_W-1:0] OP_PTR_CLR     = 5'd15;
    localparam logic [OP_W-1:0] OP_FLUSH_CLR   = 5'd16;

    typedef struct packed {
        logic                 ack;
        logic [TAG_BITS-1:0]  tag;
    } send_entry_t;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [STATUS_W-1:0] status;
        logic                last;
    } cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              send_full;
        logic              send_empty;
        logic              pend_full;
        logic              pend_empty;
        logic              resend;
        logic              head_ack;
        logic              over_window;
        logic              ptr_in_send;
        logic              ptr_in_pend;
        logic              send_ptr_ack;
        logic              pend_ptr_hit;
        logic              pend_last;
        logic              send_last;
        logic              out_free;
    } stat_t;

endpackage

// File: rtl/atsq_dp.sv
// Datapath: send queue and pending list storage, counters, scan pointer,
// window register and result/output registers. Depends on atsq_pkg.
`timescale 1ns / 1ps

module atsq_dp import atsq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [WIN_W-1:0]    cfg_wdata,
    input  logic [MODE_W-1:0]   mode,
    input  logic [TAG_W-1:0]    tag,
    input  logic                ackable,
    input  cmd_t                cmd,
    output stat_t               stat,
    input  logic                rsp_stall,
    output logic                rsp_valid,
    output logic [STATUS_W-1:0] status,
    output logic [TAG_W-1:0]    out_tag,
    output logic                out_valid,
    output logic                start_timer,
    output logic [SLOTS_W-1:0]  free_slots,
    output logic                last
);

    // Storage (contents beyond the counts are never used)
    send_entry_t         send_q_reg [QUEUE_DEPTH];
    send_entry_t         send_q_next[QUEUE_DEPTH];
    logic [TAG_BITS-1:0] pend_q_reg [QUEUE_DEPTH];
    logic [TAG_BITS-1:0] pend_q_next[QUEUE_DEPTH];

    // Control state
    logic [CNT_W-1:0] scount_reg, scount_next;
    logic [CNT_W-1:0] pcount_reg, pcount_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic             resend_reg, resend_next;
    logic [WIN_W-1:0] win_reg, win_next;
    logic             rsp_valid_reg, rsp_valid_next;

    // Latched request
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic                ack_reg, ack_next;

    // Pending result
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [TAG_BITS-1:0] res_tag_reg, res_tag_next;
    logic                res_pkt_reg, res_pkt_next;
    logic                res_tm_reg, res_tm_next;

    // Output register
    logic [STATUS_W-1:0] o_status_reg, o_status_next;
    logic [TAG_BITS-1:0] o_tag_reg, o_tag_next;
    logic                o_pkt_reg, o_pkt_next;
    logic                o_tm_reg, o_tm_next;
    logic [SLOTS_W-1:0]  o_free_reg, o_free_next;
    logic                o_last_reg, o_last_next;

    send_entry_t         send_ptr;
    logic [TAG_BITS-1:0] pend_ptr;
    logic [CNT_W:0]      ptr_plus1;
    logic                out_free;

    assign send_ptr  = send_q_reg[ptr_reg[IDX_W-1:0]];
    assign pend_ptr  = pend_q_reg[ptr_reg[IDX_W-1:0]];
    assign ptr_plus1 = (CNT_W+1)'(ptr_reg) + (CNT_W+1)'(1);
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        stat.mode         = mode_reg;
        stat.send_full    = (scount_reg == CNT_W'(QUEUE_DEPTH));
        stat.send_empty   = (scount_reg == '0);
        stat.pend_full    = (pcount_reg == CNT_W'(QUEUE_DEPTH));
        stat.pend_empty   = (pcount_reg == '0);
        stat.resend       = resend_reg;
        stat.head_ack     = send_q_reg[0].ack;
        stat.over_window  = (7'(pcount_reg) > 7'(win_reg));
        stat.ptr_in_send  = (ptr_reg < scount_reg);
        stat.ptr_in_pend  = (ptr_reg < pcount_reg);
        stat.send_ptr_ack = send_ptr.ack;
        stat.pend_ptr_hit = (pend_ptr == tag_reg);
        stat.pend_last    = (ptr_plus1 == (CNT_W+1)'(pcount_reg));
        stat.send_last    = (ptr_plus1 == (CNT_W+1)'(scount_reg));
        stat.out_free     = out_free;
    end

    always_comb
    begin
        send_q_next     = send_q_reg;
        pend_q_next     = pend_q_reg;
        scount_next     = scount_reg;
        pcount_next     = pcount_reg;
        ptr_next        = ptr_reg;
        resend_next     = resend_reg;
        win_next        = cfg_we ? cfg_wdata : win_reg;
        mode_next       = mode_reg;
        tag_next        = tag_reg;
        ack_next        = ack_reg;
        res_status_next = res_status_reg;
        res_tag_next    = res_tag_reg;
        res_pkt_next    = res_pkt_reg;
        res_tm_next     = res_tm_reg;
        o_status_next   = o_status_reg;
        o_tag_next      = o_tag_reg;
        o_pkt_next      = o_pkt_reg;
        o_tm_next       = o_tm_reg;
        o_free_next     = o_free_reg;
        o_last_next     = o_last_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;

        unique case (cmd.op)
            OP_LATCH:
            begin
                mode_next = mode;
                tag_next  = TAG_BITS'(tag);
                ack_next  = ackable;
                ptr_next  = '0;
            end
            OP_ENQ:
            begin
                send_q_next[scount_reg[IDX_W-1:0]] = '{ack: ack_reg, tag: tag_reg};
                scount_next     = scount_reg + CNT_W'(1);
                res_status_next = ST_OK;
                res_tag_next    = '0;
                res_pkt_next    = 1'b0;
                res_tm_next     = 1'b0;
            end
            OP_RESULT:
            begin
                res_status_next = cmd.status;
                res_tag_next    = '0;
                res_pkt_next    = 1'b0;
                res_tm_next     = 1'b0;
            end
            OP_RESEND:
            begin
                resend_next     = 1'b0;
                res_status_next = ST_OK;
                res_tag_next    = pend_q_reg[0];
                res_pkt_next    = 1'b1;
                res_tm_next     = 1'b0;
            end
            OP_CLR_RESEND:
            begin
                resend_next = 1'b0;
            end
            OP_SEND_HEAD:
            begin
                for (int k = 0; k < QUEUE_DEPTH - 1; k++)
                    send_q_next[k] = send_q_reg[k+1];
                scount_next     = scount_reg - CNT_W'(1);
                res_status_next = ST_OK;
                res_tag_next    = send_q_reg[0].tag;
                res_pkt_next    = 1'b1;
                res_tm_next     = 1'b0;
            end
            OP_SEND_TRACK:
            begin
                for (int k = 0; k < QUEUE_DEPTH - 1; k++)
                    send_q_next[k] = send_q_reg[k+1];
                pend_q_next[pcount_reg[IDX_W-1:0]] = send_q_reg[0].tag;
                scount_next     = scount_reg - CNT_W'(1);
                pcount_next     = pcount_reg + CNT_W'(1);
                res_status_next = ST_OK;
                res_tag_next    = send_q_reg[0].tag;
                res_pkt_next    = 1'b1;
                res_tm_next     = 1'b1;
            end
            OP_SCAN_NEXT:
            begin
                ptr_next = ptr_reg + CNT_W'(1);
            end
            OP_SEND_AT_PTR:
            begin
                for (int k = 0; k < QUEUE_DEPTH - 1; k++)
                    if (CNT_W'(k) >= ptr_reg)
                        send_q_next[k] = send_q_reg[k+1];
                scount_next     = scount_reg - CNT_W'(1);
                res_status_next = ST_OK;
                res_tag_next    = send_ptr.tag;
                res_pkt_next    = 1'b1;
                res_tm_next     = 1'b0;
            end
            OP_PEND_RM:
            begin
                for (int k = 0; k < QUEUE_DEPTH - 1; k++)
                    if (CNT_W'(k) >= ptr_reg)
                        pend_q_next[k] = pend_q_reg[k+1];
                pcount_next     = pcount_reg - CNT_W'(1);
                res_status_next = ST_OK;
                res_tag_next    = '0;
                res_pkt_next    = 1'b0;
                res_tm_next     = 1'b0;
            end
            OP_TMO_PUSH:
            begin
                for (int k = 1; k < QUEUE_DEPTH; k++)
                    pend_q_next[k] = pend_q_reg[k-1];
                pend_q_next[0]  = tag_reg;
                pcount_next     = pcount_reg + CNT_W'(1);
                resend_next     = 1'b1;
                res_status_next = ST_OK;
                res_tag_next    = '0;
                res_pkt_next    = 1'b0;
                res_tm_next     = 1'b0;
            end
            OP_OUT_RES:
            begin
                rsp_valid_next = 1'b1;
                o_status_next  = res_status_reg;
                o_tag_next     = res_tag_reg;
                o_pkt_next     = res_pkt_reg;
                o_tm_next      = res_tm_reg;
                o_free_next    = SLOTS_W'(CNT_W'(QUEUE_DEPTH) - scount_reg);
                o_last_next    = 1'b1;
            end
            OP_OUT_PEND:
            begin
                rsp_valid_next = 1'b1;
                o_status_next  = ST_OK;
                o_tag_next     = pend_ptr;
                o_pkt_next     = 1'b1;
                o_tm_next      = 1'b0;
                o_free_next    = SLOTS_W'(QUEUE_DEPTH);
                o_last_next    = cmd.last;
                ptr_next       = ptr_reg + CNT_W'(1);
            end
            OP_OUT_SEND:
            begin
                rsp_valid_next = 1'b1;
                o_status_next  = ST_OK;
                o_tag_next     = send_ptr.tag;
                o_pkt_next     = 1'b1;
                o_tm_next      = 1'b0;
                o_free_next    = SLOTS_W'(QUEUE_DEPTH);
                o_last_next    = cmd.last;
                ptr_next       = ptr_reg + CNT_W'(1);
            end
            OP_PTR_CLR:
            begin
                ptr_next = '0;
            end
            OP_FLUSH_CLR:
            begin
                scount_next     = '0;
                pcount_next     = '0;
                resend_next     = 1'b0;
                res_status_next = cmd.status;
                res_tag_next    = '0;
                res_pkt_next    = 1'b0;
                res_tm_next     = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scount_reg    <= '0;
            pcount_reg    <= '0;
            ptr_reg       <= '0;
            resend_reg    <= 1'b0;
            win_reg       <= WIN_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            scount_reg    <= scount_next;
            pcount_reg    <= pcount_next;
            ptr_reg       <= ptr_next;
            resend_reg    <= resend_next;
            win_reg       <= win_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        send_q_reg     <= send_q_next;
        pend_q_reg     <= pend_q_next;
        mode_reg       <= mode_next;
        tag_reg        <= tag_next;
        ack_reg        <= ack_next;
        res_status_reg <= res_status_next;
        res_tag_reg    <= res_tag_next;
        res_pkt_reg    <= res_pkt_next;
        res_tm_reg     <= res_tm_next;
        o_status_reg   <= o_status_next;
        o_tag_reg      <= o_tag_next;
        o_pkt_reg      <= o_pkt_next;
        o_tm_reg       <= o_tm_next;
        o_free_reg     <= o_free_next;
        o_last_reg     <= o_last_next;
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = o_status_reg;
    assign out_tag     = TAG_W'(o_tag_reg);
    assign out_valid   = o_pkt_reg;
    assign start_timer = o_tm_reg;
    assign free_slots  = o_free_reg;
    assign last        = o_last_reg;

endmodule

// File: rtl/atsq_ctrl.sv
// Controller state machine: decodes each item and sequences the datapath
// through scans, updates and result delivery. Depends on atsq_pkg.
`timescale 1ns / 1ps

module atsq_ctrl import atsq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_DEQ      = 4'd2;
    localparam logic [3:0] S_DEQ_SCAN = 4'd3;
    localparam logic [3:0] S_ACK_SCAN = 4'd4;
    localparam logic [3:0] S_TMO_SCAN = 4'd5;
    localparam logic [3:0] S_FL_PEND  = 4'd6;
    localparam logic [3:0] S_FL_SEND  = 4'd7;
    localparam logic [3:0] S_FL_CLR   = 4'd8;
    localparam logic [3:0] S_RESP     = 4'd9;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        req_stall  = 1'b1;
        cmd.op     = OP_NONE;
        cmd.status = ST_OK;
        cmd.last   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.op     = OP_LATCH;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.mode)
                    MODE_ENQ:
                    begin
                        if (stat.send_full)
                        begin
                            cmd.op     = OP_RESULT;
                            cmd.status = ST_FULL;
                        end
                        else
                            cmd.op = OP_ENQ;
                        state_next = S_RESP;
                    end
                    MODE_DEQ:
                    begin
                        // resend with an empty pending list drops the flag and dequeues
                        if (stat.resend && !stat.pend_empty)
                        begin
                            cmd.op     = OP_RESEND;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            cmd.op     = OP_CLR_RESEND;
                            state_next = S_DEQ;
                        end
                    end
                    MODE_ACK:     state_next = S_ACK_SCAN;
                    MODE_TIMEOUT: state_next = S_TMO_SCAN;
                    MODE_FLUSH:   state_next = S_FL_PEND;
                    default:
                    begin
                        cmd.op     = OP_RESULT;
                        cmd.status = ST_OK;
                        state_next = S_RESP;
                    end
                endcase
            end
            S_DEQ:
            begin
                priority if (stat.send_empty)
                begin
                    cmd.op     = OP_RESULT;
                    cmd.status = ST_EMPTY;
                    state_next = S_RESP;
                end
                else if (!stat.head_ack)
                begin
                    cmd.op     = OP_SEND_HEAD;
                    state_next = S_RESP;
                end
                else if (stat.over_window || stat.pend_full)
                    state_next = S_DEQ_SCAN;
                else
                begin
                    cmd.op     = OP_SEND_TRACK;
                    state_next = S_RESP;
                end
            end
            S_DEQ_SCAN:
            begin
                priority if (!stat.ptr_in_send)
                begin
                    cmd.op     = OP_RESULT;
                    cmd.status = ST_NO_SEND;
                    state_next = S_RESP;
                end
                else if (!stat.send_ptr_ack)
                begin
                    cmd.op     = OP_SEND_AT_PTR;
                    state_next = S_RESP;
                end
                else
                    cmd.op = OP_SCAN_NEXT;
            end
            S_ACK_SCAN:
            begin
                priority if (!stat.ptr_in_pend)
                begin
                    cmd.op     = OP_RESULT;
                    cmd.status = ST_NOT_FOUND;
                    state_next = S_RESP;
                end
                else if (stat.pend_ptr_hit)
                begin
                    cmd.op     = OP_PEND_RM;
                    state_next = S_RESP;
                end
                else
                    cmd.op = OP_SCAN_NEXT;
            end
            S_TMO_SCAN:
            begin
                // drop every copy of the tag, then push it at the head unless the list is full
                priority if (!stat.ptr_in_pend)
                begin
                    if (stat.pend_full)
                    begin
                        cmd.op     = OP_RESULT;
                        cmd.status = ST_FULL;
                    end
                    else
                        cmd.op = OP_TMO_PUSH;
                    state_next = S_RESP;
                end
                else if (stat.pend_ptr_hit)
                    cmd.op = OP_PEND_RM;
                else
                    cmd.op = OP_SCAN_NEXT;
            end
            S_FL_PEND:
            begin
                priority if (!stat.ptr_in_pend)
                begin
                    cmd.op     = OP_PTR_CLR;
                    state_next = S_FL_SEND;
                end
                else if (stat.out_free)
                begin
                    cmd.op   = OP_OUT_PEND;
                    cmd.last = stat.pend_last && stat.send_empty;
                    if (cmd.last)
                        state_next = S_FL_CLR;
                end
                else
                    state_next = S_FL_PEND;
            end
            S_FL_SEND:
            begin
                priority if (!stat.ptr_in_send)
                begin
                    // both queues were empty: one empty result
                    cmd.op     = OP_FLUSH_CLR;
                    cmd.status = ST_EMPTY;
                    state_next = S_RESP;
                end
                else if (stat.out_free)
                begin
                    cmd.op   = OP_OUT_SEND;
                    cmd.last = stat.send_last;
                    if (cmd.last)
                        state_next = S_FL_CLR;
                end
                else
                    state_next = S_FL_SEND;
            end
            S_FL_CLR:
            begin
                cmd.op     = OP_FLUSH_CLR;
                state_next = S_IDLE;
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_OUT_RES;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: rtl/ack_tracking_send_queue_core.sv
// Top level of the ack-tracking send queue: controller plus datapath.
// Depends on atsq_pkg, atsq_ctrl and atsq_dp.
`timescale 1ns / 1ps
//
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------------
//  request | req_valid / req_stall  | mode, tag, ackable
//  result  | rsp_valid / rsp_stall  | status, out_tag, out_valid, start_timer,
//          |                        | free_slots, last
//  config  | cfg_we (no wait)       | cfg_wdata = ack window limit
//
//  One item is worked on at a time; the controller walks it through the
//  datapath. Enqueue, resend and unused modes go from decode straight to the
//  result state; a plain or tracked dequeue passes the dequeue state first.
//  Ack and timeout visit pending entries one a cycle (a dropped copy costs
//  its cycle like any other entry) plus one closing check. A held-back
//  dequeue scans the send queue the same way. Flush loads one result a cycle
//  while the result channel is not stalled, pending entries then queued
//  entries, with a pointer clear between the two; with both empty it loads a
//  single empty result. Reset clears the counts, the resend flag and the
//  result valid, and loads the window limit with 8; the entry arrays need no
//  clearing. A stalled result holds in the output register and holds the
//  controller with it; the next item is accepted only after the last result
//  is loaded and the controller is back in idle.

module ack_tracking_send_queue_core import atsq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // configuration
    input  logic                cfg_we,
    input  logic [WIN_W-1:0]    cfg_wdata,
    // request channel
    input  logic                req_valid,
    output logic                req_stall,
    input  logic [MODE_W-1:0]   mode,
    input  logic [TAG_W-1:0]    tag,
    input  logic                ackable,
    // result channel
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic [STATUS_W-1:0] status,
    output logic [TAG_W-1:0]    out_tag,
    output logic                out_valid,
    output logic                start_timer,
    output logic [SLOTS_W-1:0]  free_slots,
    output logic                last
);

    cmd_t  cmd;
    stat_t stat;

    // Sequence each item: decode, scan, update, deliver
    atsq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Hold both queues, the counters and the output register
    atsq_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .mode        (mode),
        .tag         (tag),
        .ackable     (ackable),
        .cmd         (cmd),
        .stat        (stat),
        .rsp_stall   (rsp_stall),
        .rsp_valid   (rsp_valid),
        .status      (status),
        .out_tag     (out_tag),
        .out_valid   (out_valid),
        .start_timer (start_timer),
        .free_slots  (free_slots),
        .last        (last)
    );

endmodule

// File: rtl/atsq_checker.sv
// Port-level checks for the ack-tracking send queue, bound to the top level.
// Depends on atsq_pkg and ack_tracking_send_queue_core.
`timescale 1ns / 1ps

module atsq_checker import atsq_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_stall,
    input logic                rsp_valid,
    input logic                rsp_stall,
    input logic [STATUS_W-1:0] status,
    input logic [TAG_W-1:0]    out_tag,
    input logic                out_valid,
    input logic                start_timer,
    input logic                last
);

    // a stalled result stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("result dropped while stalled");

    // one item at a time: the cycle after an accept is stalled
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("second item accepted back to back");

    a_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !out_valid |-> out_tag == '0)
        else $error("tag present without a packet");

    a_timer: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && start_timer |-> out_valid && status == ST_OK)
        else $error("timer start without a sent packet");

    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != ST_OK |-> !out_valid && last)
        else $error("error result carries a packet or is not final");

endmodule

bind ack_tracking_send_queue_core atsq_checker u_atsq_checker (.*);
